### rtl/tcbr_pkg.sv
// Package for the temperature calibration bin and re-initialisation control.
// Holds field widths, register indexes, reset values and shared types.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package tcbr_pkg;

   localparam int unsigned MASK_BITS      = 12;
   localparam int unsigned SPEED_BITS     = 12;
   localparam int unsigned TEMP_BITS      = 12;
   localparam int unsigned HYST_BITS      = 8;
   localparam int unsigned RETRY_BITS     = 10;
   localparam int unsigned COUNT_BITS     = 3;
   localparam int unsigned BIN_BITS       = 2;
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 12;

   typedef logic [BIN_BITS-1:0]          bin_type;
   typedef logic signed [TEMP_BITS-1:0]  temp_type;
   typedef logic [HYST_BITS-1:0]         hyst_type;
   typedef logic [COUNT_BITS-1:0]        count_type;

   localparam bin_type DEFAULT_BIN = bin_type'(3);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD_COUNT = 3'd0,
      CSR_THRESHOLD_LOW   = 3'd1,
      CSR_THRESHOLD_MID   = 3'd2,
      CSR_THRESHOLD_HIGH  = 3'd3,
      CSR_HYSTERESIS      = 3'd4,
      CSR_RETRY_DELAY     = 3'd5,
      CSR_MIN_SPEED       = 3'd6
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam count_type               RST_THRESHOLD_COUNT = count_type'(3);
   localparam temp_type                RST_THRESHOLD_LOW   = temp_type'(0);
   localparam temp_type                RST_THRESHOLD_MID   = temp_type'(200);
   localparam temp_type                RST_THRESHOLD_HIGH  = temp_type'(400);
   localparam hyst_type                RST_HYSTERESIS      = hyst_type'(20);
   localparam logic [RETRY_BITS-1:0]   RST_RETRY_DELAY     = RETRY_BITS'(250);
   localparam logic [SPEED_BITS-1:0]   RST_MIN_SPEED       = SPEED_BITS'(170);

   // Bin boundary configuration as seen by the bin selector.
   typedef struct packed {
      count_type threshold_count;
      temp_type  threshold_low;
      temp_type  threshold_mid;
      temp_type  threshold_high;
   } bounds_type;

endpackage

`default_nettype wire

### rtl/tcbr_if.sv
// Channel interfaces of the temperature calibration bin control block.
// Request, response and configuration-write channels with valid/ready.
// Depends on tcbr_pkg for field widths.
`default_nettype none

interface tcbr_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  speed_valid;
   logic [tcbr_pkg::SPEED_BITS-1:0]       vehicle_speed;
   logic                                  in_park;
   logic                                  control_halted;
   logic [tcbr_pkg::MASK_BITS-1:0]        disconnect_mask;
   logic                                  comm_unknown;
   logic                                  sensor_fail;
   logic                                  temp_valid;
   logic signed [tcbr_pkg::TEMP_BITS-1:0] ambient_temp;

   modport source (
      output valid, speed_valid, vehicle_speed, in_park, control_halted,
             disconnect_mask, comm_unknown, sensor_fail, temp_valid, ambient_temp,
      input  ready
   );
   modport sink (
      input  valid, speed_valid, vehicle_speed, in_park, control_halted,
             disconnect_mask, comm_unknown, sensor_fail, temp_valid, ambient_temp,
      output ready
   );
endinterface

interface tcbr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             reconfig_trigger;
   logic                             temp_adjust_request;
   logic [tcbr_pkg::BIN_BITS-1:0]    calibration_bin;

   modport source (
      output valid, reconfig_trigger, temp_adjust_request, calibration_bin,
      input  ready
   );
   modport sink (
      input  valid, reconfig_trigger, temp_adjust_request, calibration_bin,
      output ready
   );
endinterface

interface tcbr_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [tcbr_pkg::CSR_INDEX_BITS-1:0]   index;
   logic [tcbr_pkg::CSR_DATA_BITS-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/temp_calibration_bin_reinit_control_unit.sv
// Top level of the temperature calibration bin and re-initialisation control.
// Depends on tcbr_pkg, the channel interfaces in tcbr_if and tcbr_bin_select.
//
//   Channel  Direction  Carries
//   req      in         one tick of vehicle, fault and temperature status
//   rsp      out        reconfiguration trigger, adjust request, bin in use
//   csr      in         register index and write data
//
// Every request gives exactly one response, through the input register and then
// the response register. A new request is taken in every cycle while the
// response side keeps up, set by the single pass of compare logic between them.
// Reset is synchronous and active high; it restores register defaults and the
// tick state. A stalled response holds the input register, so the request
// side is only held off once both registers are full.
`default_nettype none

module temp_calibration_bin_reinit_control_unit (
   input  var logic     clock,
   input  var logic     reset,
   tcbr_req_if.sink     req_chan,
   tcbr_rsp_if.source   rsp_chan,
   tcbr_csr_if.sink     csr_chan
);

   // Configuration registers.
   tcbr_pkg::count_type                    threshold_count_ff;
   tcbr_pkg::temp_type                     threshold_low_ff;
   tcbr_pkg::temp_type                     threshold_mid_ff;
   tcbr_pkg::temp_type                     threshold_high_ff;
   tcbr_pkg::hyst_type                     hysteresis_ff;
   logic [tcbr_pkg::RETRY_BITS-1:0]        retry_delay_ff;
   logic [tcbr_pkg::SPEED_BITS-1:0]        min_speed_ff;

   // Tick state carried from one request to the next.
   tcbr_pkg::bin_type                      used_bin_ff, used_bin_in;
   logic [tcbr_pkg::RETRY_BITS-1:0]        retry_count_ff, retry_count_in;
   logic                                   fault_seen_ff, fault_seen_in;
   logic                                   first_action_done_ff, first_action_done_in;
   logic [tcbr_pkg::MASK_BITS-1:0]         last_fault_mask_ff, last_fault_mask_in;

   // Input register.
   logic                                   req_valid_ff;
   logic                                   speed_valid_ff;
   logic [tcbr_pkg::SPEED_BITS-1:0]        vehicle_speed_ff;
   logic                                   in_park_ff;
   logic                                   control_halted_ff;
   logic [tcbr_pkg::MASK_BITS-1:0]         disconnect_mask_ff;
   logic                                   comm_unknown_ff;
   logic                                   sensor_fail_ff;
   logic                                   temp_valid_ff;
   tcbr_pkg::temp_type                     ambient_temp_ff;

   // Response register.
   logic                                   rsp_valid_ff;
   logic                                   reconfig_ff, reconfig_in;
   logic                                   adjust_ff, adjust_in;

   logic                                   advance;
   logic                                   req_take;
   logic                                   action_allowed;
   logic                                   fault_pending;
   logic                                   use_hyst;
   tcbr_pkg::hyst_type                     select_hyst;
   tcbr_pkg::bin_type                      selected_bin;
   tcbr_pkg::bounds_type                   bounds;

   // The item in the input register moves on when the response slot is free
   // or is being emptied in this cycle; the tick state updates at that edge.
   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !req_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.reconfig_trigger    = reconfig_ff;
   assign rsp_chan.temp_adjust_request = adjust_ff;
   assign rsp_chan.calibration_bin     = used_bin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_count_ff <= tcbr_pkg::RST_THRESHOLD_COUNT;
         threshold_low_ff   <= tcbr_pkg::RST_THRESHOLD_LOW;
         threshold_mid_ff   <= tcbr_pkg::RST_THRESHOLD_MID;
         threshold_high_ff  <= tcbr_pkg::RST_THRESHOLD_HIGH;
         hysteresis_ff      <= tcbr_pkg::RST_HYSTERESIS;
         retry_delay_ff     <= tcbr_pkg::RST_RETRY_DELAY;
         min_speed_ff       <= tcbr_pkg::RST_MIN_SPEED;
      end else if (csr_chan.valid) begin
         // Writes to an index beyond the register list are dropped.
         case (csr_chan.index)
            tcbr_pkg::CSR_THRESHOLD_COUNT: begin
               threshold_count_ff <= csr_chan.data[tcbr_pkg::COUNT_BITS-1:0];
            end
            tcbr_pkg::CSR_THRESHOLD_LOW: begin
               threshold_low_ff <= $signed(csr_chan.data[tcbr_pkg::TEMP_BITS-1:0]);
            end
            tcbr_pkg::CSR_THRESHOLD_MID: begin
               threshold_mid_ff <= $signed(csr_chan.data[tcbr_pkg::TEMP_BITS-1:0]);
            end
            tcbr_pkg::CSR_THRESHOLD_HIGH: begin
               threshold_high_ff <= $signed(csr_chan.data[tcbr_pkg::TEMP_BITS-1:0]);
            end
            tcbr_pkg::CSR_HYSTERESIS: begin
               hysteresis_ff <= csr_chan.data[tcbr_pkg::HYST_BITS-1:0];
            end
            tcbr_pkg::CSR_RETRY_DELAY: begin
               retry_delay_ff <= csr_chan.data[tcbr_pkg::RETRY_BITS-1:0];
            end
            tcbr_pkg::CSR_MIN_SPEED: begin
               min_speed_ff <= csr_chan.data[tcbr_pkg::SPEED_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Input register: control bit under reset, payload loaded on acceptance.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (advance) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         speed_valid_ff     <= req_chan.speed_valid;
         vehicle_speed_ff   <= req_chan.vehicle_speed;
         in_park_ff         <= req_chan.in_park;
         control_halted_ff  <= req_chan.control_halted;
         disconnect_mask_ff <= req_chan.disconnect_mask;
         comm_unknown_ff    <= req_chan.comm_unknown;
         sensor_fail_ff     <= req_chan.sensor_fail;
         temp_valid_ff      <= req_chan.temp_valid;
         ambient_temp_ff    <= req_chan.ambient_temp;
      end
   end

   assign bounds.threshold_count = threshold_count_ff;
   assign bounds.threshold_low   = threshold_low_ff;
   assign bounds.threshold_mid   = threshold_mid_ff;
   assign bounds.threshold_high  = threshold_high_ff;

   assign action_allowed = (vehicle_speed_ff >= min_speed_ff) || in_park_ff
                           || control_halted_ff;
   assign fault_pending  = (|disconnect_mask_ff) || comm_unknown_ff || sensor_fail_ff;

   // Hysteresis applies only on the normal path once a first action is done;
   // fault and recovery selection always use the bare boundaries.
   assign use_hyst    = !fault_pending && !fault_seen_ff && first_action_done_ff;
   assign select_hyst = use_hyst ? hysteresis_ff : '0;

   tcbr_bin_select u_bin_select (
      .bounds   (bounds),
      .temp     (ambient_temp_ff),
      .hyst     (select_hyst),
      .prev_bin (used_bin_ff),
      .bin      (selected_bin)
   );

   // Tick decision for the item in the input register.
   always_comb begin
      used_bin_in          = used_bin_ff;
      retry_count_in       = retry_count_ff;
      fault_seen_in        = fault_seen_ff;
      first_action_done_in = first_action_done_ff;
      last_fault_mask_in   = last_fault_mask_ff;
      reconfig_in          = 1'b0;
      adjust_in            = 1'b0;

      if (!speed_valid_ff) begin
         first_action_done_in = 1'b0;
      end else if (action_allowed) begin
         if (fault_pending) begin
            // Reconfigure when the retry countdown has run out or the set of
            // disconnected sensors has changed since the last tick with a fault pending.
            fault_seen_in = 1'b1;
            if (retry_count_ff == '0 || last_fault_mask_ff != disconnect_mask_ff) begin
               if (temp_valid_ff) begin
                  used_bin_in = selected_bin;
               end
               reconfig_in          = 1'b1;
               retry_count_in       = retry_delay_ff;
               first_action_done_in = 1'b1;
            end else begin
               retry_count_in = retry_count_ff - 1'b1;
            end
            last_fault_mask_in = disconnect_mask_ff;
         end else if (fault_seen_ff) begin
            // Recovery: reselect the bin and reconfigure only if it moved.
            if (temp_valid_ff && selected_bin != used_bin_ff) begin
               used_bin_in = selected_bin;
               reconfig_in = 1'b1;
            end
            retry_count_in       = retry_delay_ff;
            first_action_done_in = 1'b1;
            fault_seen_in        = 1'b0;
         end else if (temp_valid_ff) begin
            if (selected_bin != used_bin_ff) begin
               used_bin_in          = selected_bin;
               adjust_in            = 1'b1;
               first_action_done_in = 1'b1;
            end
         end
      end else begin
         first_action_done_in = 1'b0;
         retry_count_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_bin_ff          <= tcbr_pkg::DEFAULT_BIN;
         retry_count_ff       <= '0;
         fault_seen_ff        <= 1'b0;
         first_action_done_ff <= 1'b0;
         last_fault_mask_ff   <= '0;
      end else if (advance) begin
         used_bin_ff          <= used_bin_in;
         retry_count_ff       <= retry_count_in;
         fault_seen_ff        <= fault_seen_in;
         first_action_done_ff <= first_action_done_in;
         last_fault_mask_ff   <= last_fault_mask_in;
      end
   end

   // Response register. The bin shown is the tick state itself, which only
   // changes when the next item moves into this register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         reconfig_ff <= reconfig_in;
         adjust_ff   <= adjust_in;
      end
   end

endmodule

`default_nettype wire

### rtl/tcbr_bin_select.sv
// Temperature bin selector: compares a temperature against up to three
// boundaries widened by a hysteresis band. Depends on tcbr_pkg.
`default_nettype none

module tcbr_bin_select (
   input  var tcbr_pkg::bounds_type bounds,
   input  var tcbr_pkg::temp_type   temp,
   input  var tcbr_pkg::hyst_type   hyst,
   input  var tcbr_pkg::bin_type    prev_bin,
   output var tcbr_pkg::bin_type    bin
);

   localparam int unsigned WIDE = tcbr_pkg::TEMP_BITS + 2;

   logic signed [WIDE-1:0] temp_wide;
   logic signed [WIDE-1:0] hyst_wide;
   logic signed [WIDE-1:0] bound_wide [3];
   logic [2:0]             le_low;
   logic [2:0]             gt_high;

   assign temp_wide  = WIDE'(temp);
   assign hyst_wide  = $signed({{(WIDE-tcbr_pkg::HYST_BITS){1'b0}}, hyst});
   assign bound_wide[0] = WIDE'(bounds.threshold_low);
   assign bound_wide[1] = WIDE'(bounds.threshold_mid);
   assign bound_wide[2] = WIDE'(bounds.threshold_high);

   // Per boundary: at or below the lower edge, or above the upper edge.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         le_low[k]  = temp_wide <= (bound_wide[k] - hyst_wide);
         gt_high[k] = temp_wide >  (bound_wide[k] + hyst_wide);
      end
   end

   // In a hysteresis band prev_bin stays; count 0 or >3: DEFAULT_BIN.
   always_comb begin
      bin = prev_bin;
      case (bounds.threshold_count)
         3'd1: begin
            if (le_low[0]) bin = 2'd0;
            else if (gt_high[0]) bin = 2'd1;
         end
         3'd2: begin
            if (le_low[0]) bin = 2'd0;
            else if (gt_high[1]) bin = 2'd2;
            else if (gt_high[0] && le_low[1]) bin = 2'd1;
         end
         3'd3: begin
            if (le_low[0]) bin = 2'd0;
            else if (gt_high[2]) bin = 2'd3;
            else if (gt_high[0] && le_low[1]) bin = 2'd1;
            else if (gt_high[1] && le_low[2]) bin = 2'd2;
         end
         default: begin
            bin = tcbr_pkg::DEFAULT_BIN;
         end
      endcase
   end

endmodule

`default_nettype wire
